/* sv/wxr_pkg.sv */
`default_nettype none
package wxr_pkg;

  localparam int DEF_MAX_WORDS          = 1024;
  localparam int DEF_WORD_LETTERS       = 20;
  localparam int DEF_MAX_LINES_PER_WORD = 128;
  localparam int DEF_LINE_BITS          = 16;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_FLUSH = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } wxr_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_TABLE_FULL = 2'd1,
    ERR_LINES_FULL = 2'd2,
    ERR_BAD_INDEX  = 2'd3
  } wxr_err_t;

  typedef enum logic {
    KIND_WORD = 1'b0,
    KIND_READ = 1'b1
  } wxr_kind_t;

  typedef struct packed {
    wxr_mode_t   mode;
    logic [7:0]  char_code;
    logic [9:0]  entry_index;
    logic [6:0]  slot_index;
  } wxr_item_t;

  typedef struct packed {
    wxr_kind_t   reply_kind;
    logic [9:0]  entry_number;
    logic        is_new;
    logic        line_added;
    logic [15:0] line_number;
    wxr_err_t    error_code;
    logic [7:0]  line_count;
    logic [7:0]  word_letter;
    logic [4:0]  word_length;
    logic [10:0] entry_total;
  } wxr_res_t;

endpackage
`default_nettype wire

/* sv/wxr_if.sv */
`default_nettype none
interface wxr_in_if import wxr_pkg::*; ();
  logic      valid;
  logic      ready;
  wxr_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wxr_out_if import wxr_pkg::*; ();
  logic     valid;
  logic     ready;
  wxr_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/word_cross_reference_table.sv */
`default_nettype none
// Word cross-reference table. Text bytes (mode 0) are taken one per cycle while idle;
// letters build the current word, a newline advances the line counter. A finished word
// (on a separator or on flush, mode 1) is looked up by scanning the word memory one
// entry per cycle, as it has a single read port; no input is taken until the lookup
// result enters the output register. A read (mode 2) returns its result from S_RDOUT
// once the output register is free. Memories need no clearing pass after reset. A full
// table or full line list halts text input until reset; reads keep working.
module word_cross_reference_table import wxr_pkg::*; #(
  parameter int MAX_WORDS          = DEF_MAX_WORDS,
  parameter int WORD_LETTERS       = DEF_WORD_LETTERS,
  parameter int MAX_LINES_PER_WORD = DEF_MAX_LINES_PER_WORD,
  parameter int LINE_BITS          = DEF_LINE_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wxr_in_if.sink     in_ch,
  wxr_out_if.source  out_ch
);

  localparam int IDX_W  = $clog2(MAX_WORDS);
  localparam int EC_W   = $clog2(MAX_WORDS + 1);
  localparam int CNT_W  = $clog2(MAX_LINES_PER_WORD + 1);
  localparam int LDEPTH = MAX_WORDS * MAX_LINES_PER_WORD;
  localparam int LA_W   = $clog2(LDEPTH);
  localparam int FILL_W = $clog2(WORD_LETTERS + 1);
  localparam int ROW_W  = WORD_LETTERS * 8 + FILL_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_CNT, S_LAST, S_HIT, S_NEW, S_RDOUT
  } state_t;

  state_t                 state_r;
  logic [FILL_W-1:0]      fill_r;
  logic                   in_word_r;
  logic [LINE_BITS-1:0]   line_r;
  logic [LINE_BITS-1:0]   wline_r;
  logic [EC_W-1:0]        ec_r;
  logic                   halted_r;
  logic [7:0]             buf_r [WORD_LETTERS];
  logic [EC_W-1:0]        scan_r;
  logic                   chk_v_r;
  logic [IDX_W-1:0]       chk_idx_r;
  logic [IDX_W-1:0]       hit_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [9:0]             rd_eidx_r;
  logic [6:0]             rd_slot_r;
  logic                   rd_bad_r;
  logic                   out_valid_r;
  wxr_res_t               out_data_r;

  logic                   word_we, cnt_we, line_we;
  logic [IDX_W-1:0]       word_wa, word_ra, cnt_wa, cnt_ra;
  logic [LA_W-1:0]        line_wa, line_ra;
  logic [ROW_W-1:0]       word_wd, word_rd;
  logic [CNT_W-1:0]       cnt_wd, cnt_rd;
  logic [LINE_BITS-1:0]   line_rd;

  logic                   out_free;
  logic                   accept;
  logic                   is_letter;
  logic [FILL_W-1:0]      row_len;
  logic                   word_eq;
  logic [7:0]             rd_letter;
  logic                   emit;
  logic                   set_halt;
  logic                   ec_inc;
  wxr_res_t               res;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign is_letter = (in_ch.data.char_code >= 8'd65 && in_ch.data.char_code <= 8'd90) ||
                     (in_ch.data.char_code >= 8'd97 && in_ch.data.char_code <= 8'd122);

  wxr_ram #(.DEPTH(MAX_WORDS), .WIDTH(ROW_W)) u_words (
    .clk(clk), .wr_en(word_we), .wr_addr(word_wa), .wr_data(word_wd),
    .rd_addr(word_ra), .rd_data(word_rd)
  );
  wxr_ram #(.DEPTH(MAX_WORDS), .WIDTH(CNT_W)) u_counts (
    .clk(clk), .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
    .rd_addr(cnt_ra), .rd_data(cnt_rd)
  );
  wxr_ram #(.DEPTH(LDEPTH), .WIDTH(LINE_BITS)) u_lines (
    .clk(clk), .wr_en(line_we), .wr_addr(line_wa), .wr_data(wline_r),
    .rd_addr(line_ra), .rd_data(line_rd)
  );

  assign row_len = word_rd[ROW_W-1 -: FILL_W];

  always_comb begin
    word_eq   = (row_len == fill_r);
    rd_letter = 8'd0;
    for (int i = 0; i < WORD_LETTERS; i++) begin
      if (i < 32'(fill_r) && word_rd[i*8 +: 8] != buf_r[i]) begin
        word_eq = 1'b0;
      end
      if (32'(rd_slot_r) == i && i < 32'(row_len)) begin
        rd_letter = word_rd[i*8 +: 8];
      end
    end
  end

  // read addresses are held steady while a result waits for the output register
  always_comb begin
    unique case (state_r)
      S_IDLE:  begin
        word_ra = IDX_W'(in_ch.data.entry_index);
        cnt_ra  = IDX_W'(in_ch.data.entry_index);
        line_ra = LA_W'(32'(in_ch.data.entry_index) * MAX_LINES_PER_WORD +
                        32'(in_ch.data.slot_index));
      end
      S_RDOUT: begin
        word_ra = IDX_W'(rd_eidx_r);
        cnt_ra  = IDX_W'(rd_eidx_r);
        line_ra = LA_W'(32'(rd_eidx_r) * MAX_LINES_PER_WORD + 32'(rd_slot_r));
      end
      S_LAST:  begin
        word_ra = IDX_W'(scan_r);
        cnt_ra  = hit_r;
        line_ra = LA_W'(32'(hit_r) * MAX_LINES_PER_WORD + 32'(cnt_rd) - 1);
      end
      S_HIT:   begin
        word_ra = IDX_W'(scan_r);
        cnt_ra  = hit_r;
        line_ra = LA_W'(32'(hit_r) * MAX_LINES_PER_WORD + 32'(cnt_r) - 1);
      end
      default: begin
        word_ra = IDX_W'(scan_r);
        cnt_ra  = hit_r;
        line_ra = LA_W'(32'(hit_r) * MAX_LINES_PER_WORD);
      end
    endcase
  end

  always_comb begin
    word_we  = 1'b0;
    cnt_we   = 1'b0;
    line_we  = 1'b0;
    word_wa  = IDX_W'(ec_r);
    cnt_wa   = hit_r;
    line_wa  = LA_W'(32'(hit_r) * MAX_LINES_PER_WORD + 32'(cnt_r));
    cnt_wd   = cnt_r + CNT_W'(1);
    word_wd  = {fill_r, {WORD_LETTERS*8{1'b0}}};
    for (int i = 0; i < WORD_LETTERS; i++) begin
      word_wd[i*8 +: 8] = buf_r[i];
    end
    emit     = 1'b0;
    set_halt = 1'b0;
    ec_inc   = 1'b0;
    res      = '0;
    res.reply_kind  = KIND_WORD;
    res.error_code  = ERR_NONE;
    res.line_number = 16'(wline_r);
    res.word_length = 5'(fill_r);
    res.entry_total = 11'(ec_r);
    unique case (state_r)
      S_HIT: begin
        emit = out_free;
        res.entry_number = 10'(hit_r);
        res.line_count   = 8'(cnt_r);
        if (cnt_r != '0 && line_rd == wline_r) begin
          // same line as the last one stored: nothing to add
        end else if (32'(cnt_r) >= MAX_LINES_PER_WORD) begin
          set_halt       = out_free;
          res.error_code = ERR_LINES_FULL;
        end else begin
          line_we        = out_free;
          cnt_we         = out_free;
          res.line_added = 1'b1;
          res.line_count = 8'(cnt_r + CNT_W'(1));
        end
      end
      S_NEW: begin
        emit = out_free;
        if (32'(ec_r) >= MAX_WORDS) begin
          set_halt       = out_free;
          res.error_code = ERR_TABLE_FULL;
        end else begin
          word_we          = out_free;
          cnt_we           = out_free;
          line_we          = out_free;
          ec_inc           = out_free;
          cnt_wa           = IDX_W'(ec_r);
          cnt_wd           = CNT_W'(1);
          line_wa          = LA_W'(32'(ec_r) * MAX_LINES_PER_WORD);
          res.entry_number = 10'(ec_r);
          res.is_new       = 1'b1;
          res.line_added   = 1'b1;
          res.line_count   = 8'd1;
          res.entry_total  = 11'(ec_r + EC_W'(1));
        end
      end
      S_RDOUT: begin
        emit             = out_free;
        res.reply_kind   = KIND_READ;
        res.entry_number = rd_eidx_r;
        res.line_number  = '0;
        res.word_length  = '0;
        if (rd_bad_r) begin
          res.error_code = ERR_BAD_INDEX;
        end else begin
          res.line_count  = 8'(cnt_rd);
          res.word_letter = rd_letter;
          res.word_length = 5'(row_len);
          if (32'(rd_slot_r) < 32'(cnt_rd) && 32'(rd_slot_r) < MAX_LINES_PER_WORD) begin
            res.line_number = 16'(line_rd);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      in_word_r   <= 1'b0;
      line_r      <= LINE_BITS'(1);
      ec_r        <= '0;
      halted_r    <= 1'b0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
        state_r     <= S_IDLE;
        if (state_r != S_RDOUT) begin
          fill_r    <= '0;
          in_word_r <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (set_halt) begin
        halted_r <= 1'b1;
      end
      if (ec_inc) begin
        ec_r <= ec_r + EC_W'(1);
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_ch.data.mode)
              MODE_READ: begin
                rd_eidx_r <= in_ch.data.entry_index;
                rd_slot_r <= in_ch.data.slot_index;
                rd_bad_r  <= 32'(in_ch.data.entry_index) >= 32'(ec_r);
                state_r   <= S_RDOUT;
              end
              MODE_TEXT: begin
                if (!halted_r) begin
                  if (is_letter) begin
                    for (int i = 0; i < WORD_LETTERS; i++) begin
                      if (32'(fill_r) == i) begin
                        buf_r[i] <= in_ch.data.char_code;
                      end
                    end
                    if (32'(fill_r) < WORD_LETTERS) begin
                      fill_r <= fill_r + FILL_W'(1);
                    end
                    in_word_r <= 1'b1;
                  end else begin
                    if (in_word_r) begin
                      wline_r <= line_r;
                      scan_r  <= '0;
                      chk_v_r <= 1'b0;
                      state_r <= S_SRCH;
                    end
                    if (in_ch.data.char_code == NEWLINE_CODE && line_r != LINE_MAX) begin
                      line_r <= line_r + LINE_BITS'(1);
                    end
                  end
                end
              end
              MODE_FLUSH: begin
                if (!halted_r && in_word_r) begin
                  wline_r <= line_r;
                  scan_r  <= '0;
                  chk_v_r <= 1'b0;
                  state_r <= S_SRCH;
                end
              end
              default: ;
            endcase
          end
        end
        S_SRCH: begin
          if (chk_v_r && word_eq) begin
            hit_r   <= chk_idx_r;
            chk_v_r <= 1'b0;
            state_r <= S_CNT;
          end else if (scan_r < ec_r) begin
            chk_v_r   <= 1'b1;
            chk_idx_r <= IDX_W'(scan_r);
            scan_r    <= scan_r + EC_W'(1);
          end else begin
            chk_v_r <= 1'b0;
            if (!chk_v_r) begin
              state_r <= S_NEW;
            end
          end
        end
        S_CNT:  state_r <= S_LAST;
        S_LAST: begin
          cnt_r   <= cnt_rd;
          state_r <= S_HIT;
        end
        S_HIT, S_NEW, S_RDOUT: ;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_ec_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ec_r) <= MAX_WORDS)
    else $error("entry count beyond table size");

  a_ec_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ec_r != $past(ec_r)) |-> (ec_r == $past(ec_r) + EC_W'(1)))
    else $error("entry count moved by more than one");

  a_new_adds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.is_new) |-> out_ch.data.line_added)
    else $error("new entry without a stored line");

endmodule
`default_nettype wire

/* sv/wxr_ram.sv */
`default_nettype none
module wxr_ram import wxr_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WORDS,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
